// ----- rtl/dbcs_pkg.sv -----
`default_nettype none
package dbcs_pkg;

  localparam logic [15:0] SIGNATURE_WORD = 16'hbeef;
  localparam logic [7:0]  ERASED_BYTE    = 8'hff;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_COMPARE = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_FILL    = 3'd3,
    CMD_INIT    = 3'd4,
    CMD_FORMAT  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FORMATTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_EXEC,
    S_RDWAIT,
    S_COPY,
    S_WRITE,
    S_FORMAT,
    S_SUM,
    S_FIN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_COMMIT,
    P_INIT0,
    P_INIT1,
    P_META0
  } purpose_t;

  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [31:0] t;
    t = {16'b0, s[15:0]} + {16'b0, s[31:16]};
    return t[15:0] + t[31:16];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dbcs_ram.sv -----
`default_nettype none
module dbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/dual_bank_config_store.sv -----
// Read/compare: dispatch, execute, read wait, result beat. A write beat writes the
// staging bank, plus a bank copy on the first beat of a run and a checksum walk on
// the last; a format beat writes bank 0, plus a walk on the last; fill is copy plus
// walk. Initialize walks one to three banks through the byte RAM's single read port.
// Throughput: one command at a time; busy is high through the result beat; no stall.
// Reset: synchronous, both banks erased, bank 0 live; no clearing pass is needed.
`default_nettype none
module dual_bank_config_store #(
  parameter int DATA_BYTES = 960,
  parameter int META_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [9:0]  in_offset,
  input  wire logic [9:0]  in_length,
  input  wire logic [7:0]  in_data,
  input  wire logic        in_last,
  output logic             out_strobe,
  output logic [7:0]       out_read_data,
  output logic             out_match,
  output logic [1:0]       out_status,
  output logic             out_active_bank,
  output logic [31:0]      out_generation
);

  import dbcs_pkg::*;

  localparam int CW = $clog2(DATA_BYTES + 1);
  localparam int AW = $clog2(2 * DATA_BYTES);
  localparam logic [31:0] D32 = 32'(DATA_BYTES);
  localparam logic [31:0] FILL_SUM = 32'(65535 * ((META_BYTES - 8) / 2));

  state_t   state_r, state_nxt;
  purpose_t pur_r;
  logic [2:0]  cmd_r;
  logic [9:0]  off_r, len_r;
  logic [7:0]  dat_r;
  logic        last_r;
  logic        live_r, run_open_r, run_match_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] vld_r [2];
  logic [15:0] sig_r [2];
  logic [31:0] gen_r [2];
  logic [15:0] ck_r [2];
  logic [CW-1:0] ci_r, p_idx_r;
  logic        p_v_r, rb_r;
  logic [31:0] s_r;
  logic [7:0]  rd_r;
  logic        mt_r;
  logic [1:0]  st_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata, rg;
  logic off_ok, fill_ok, fmt_ok, issue, walk_end, fill_hit, fin_valid;
  logic        fb;
  logic [15:0] f_sig, f_ck, f_sum;
  logic [31:0] f_gen, f_tot;

  function automatic logic [AW-1:0] baddr(input logic b, input logic [CW-1:0] idx);
    return b ? AW'(DATA_BYTES) + AW'(idx) : AW'(idx);
  endfunction

  dbcs_ram #(.WIDTH(8), .DEPTH(2 * DATA_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign off_ok   = 32'(off_r) < D32;
  assign fill_ok  = 32'(off_r) + 32'(len_r) <= D32;
  assign fmt_ok   = 32'(cnt_r) < D32;
  assign issue    = ci_r != CW'(DATA_BYTES);
  assign walk_end = !issue && !p_v_r;
  assign rg       = (p_idx_r < vld_r[rb_r]) ? ram_rdata : ERASED_BYTE;
  assign fill_hit = (cmd_r == CMD_FILL) && (32'(p_idx_r) >= 32'(off_r))
                    && (32'(p_idx_r) < 32'(off_r) + 32'(len_r));

  always_comb begin
    fb    = 1'b0;
    f_sig = SIGNATURE_WORD;
    f_gen = 32'd1;
    f_ck  = 16'd0;
    case (pur_r)
      P_COMMIT: begin
        fb    = ~live_r;
        f_gen = gen_r[live_r] + 32'd1;
      end
      P_INIT0, P_INIT1: begin
        fb    = (pur_r == P_INIT1);
        f_sig = sig_r[fb];
        f_gen = gen_r[fb];
        f_ck  = ck_r[fb];
      end
      default: begin
        fb = 1'b0;
      end
    endcase
    f_tot = s_r + 32'(f_ck) + 32'(f_sig) + 32'(f_gen[15:0]) + 32'(f_gen[31:16]) + FILL_SUM;
    f_sum = fold16(f_tot);
    fin_valid = (f_sig == SIGNATURE_WORD) && (f_sum == 16'hffff);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_DISP;
      S_DISP:   state_nxt = S_EXEC;
      S_EXEC: begin
        case (cmd_r)
          CMD_READ, CMD_COMPARE: state_nxt = off_ok ? S_RDWAIT : S_DONE;
          CMD_WRITE:  state_nxt = run_open_r ? S_WRITE : S_COPY;
          CMD_FILL:   state_nxt = fill_ok ? S_COPY : S_DONE;
          CMD_INIT:   state_nxt = S_SUM;
          CMD_FORMAT: state_nxt = S_FORMAT;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_RDWAIT: state_nxt = S_DONE;
      S_COPY:   if (walk_end) state_nxt = (cmd_r == CMD_WRITE) ? S_WRITE : S_SUM;
      S_WRITE:  state_nxt = last_r ? S_SUM : S_DONE;
      S_FORMAT: state_nxt = last_r ? S_SUM : S_DONE;
      S_SUM:    if (walk_end) state_nxt = S_FIN;
      S_FIN: begin
        if ((pur_r == P_INIT0 || pur_r == P_INIT1) && !fin_valid) begin
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = state_r != S_IDLE;
    out_strobe = state_r == S_DONE;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = dat_r;
    ram_raddr  = baddr(rb_r, ci_r);
    case (state_r)
      S_EXEC: ram_raddr = baddr(live_r, CW'(off_r));
      S_COPY: begin
        ram_we    = p_v_r;
        ram_waddr = baddr(~live_r, p_idx_r);
        ram_wdata = fill_hit ? dat_r : rg;
      end
      S_WRITE: begin
        ram_we    = off_ok;
        ram_waddr = baddr(~live_r, CW'(off_r));
      end
      S_FORMAT: begin
        ram_we    = fmt_ok;
        ram_waddr = baddr(1'b0, cnt_r);
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign out_read_data   = rd_r;
  assign out_match       = mt_r;
  assign out_status      = st_r;
  assign out_active_bank = live_r;
  assign out_generation  = gen_r[live_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= 1'b0;
      run_open_r  <= 1'b0;
      run_match_r <= 1'b1;
      cnt_r       <= '0;
      p_v_r       <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        vld_r[b] <= '0;
        sig_r[b] <= 16'hffff;
        gen_r[b] <= 32'hffffffff;
        ck_r[b]  <= 16'hffff;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r  <= in_command;
            off_r  <= in_offset;
            len_r  <= in_length;
            dat_r  <= in_data;
            last_r <= in_last;
          end
        end
        S_DISP: begin
          rd_r <= '0;
          mt_r <= 1'b0;
          st_r <= ST_OK;
          if (cmd_r != CMD_COMPARE) run_match_r <= 1'b1;
          if (run_open_r && ((cmd_r == CMD_WRITE && cnt_r != '0) ||
              (cmd_r == CMD_FORMAT && cnt_r == '0) ||
              (cmd_r != CMD_WRITE && cmd_r != CMD_FORMAT))) begin
            if (cnt_r == '0) begin
              vld_r[~live_r] <= '0;
              sig_r[~live_r] <= 16'hffff;
              gen_r[~live_r] <= 32'hffffffff;
              ck_r[~live_r]  <= 16'hffff;
            end
            cnt_r      <= '0;
            run_open_r <= 1'b0;
          end
        end
        S_EXEC: begin
          rb_r    <= (cmd_r == CMD_INIT) ? 1'b0 : live_r;
          p_idx_r <= CW'(off_r);
          ci_r    <= '0;
          p_v_r   <= 1'b0;
          s_r     <= '0;
          case (cmd_r)
            CMD_READ: if (!off_ok) st_r <= ST_RANGE;
            CMD_COMPARE: begin
              if (!off_ok) begin
                st_r <= ST_RANGE;
                run_match_r <= last_r;
              end
            end
            CMD_WRITE: begin
              if (!run_open_r) begin
                run_open_r <= 1'b1;
                cnt_r      <= '0;
              end
            end
            CMD_FILL: if (!fill_ok) st_r <= ST_RANGE;
            CMD_INIT: begin
              pur_r <= P_INIT0;
            end
            CMD_FORMAT: begin
              if (!run_open_r) begin
                for (int b = 0; b < 2; b++) begin
                  vld_r[b] <= '0;
                  sig_r[b] <= 16'hffff;
                  gen_r[b] <= 32'hffffffff;
                  ck_r[b]  <= 16'hffff;
                end
                run_open_r <= 1'b1;
                cnt_r      <= '0;
              end
            end
            default: rd_r <= '0;
          endcase
        end
        S_RDWAIT: begin
          if (cmd_r == CMD_READ) begin
            rd_r <= rg;
          end else if (last_r) begin
            mt_r        <= run_match_r && (rg == dat_r);
            run_match_r <= 1'b1;
          end else if (rg != dat_r) begin
            run_match_r <= 1'b0;
          end
        end
        S_COPY: begin
          if (issue) ci_r <= ci_r + CW'(1);
          p_v_r   <= issue;
          p_idx_r <= ci_r;
          if (walk_end) begin
            vld_r[~live_r] <= CW'(DATA_BYTES);
            pur_r <= P_COMMIT;
            rb_r  <= ~live_r;
            ci_r  <= '0;
            s_r   <= '0;
          end
        end
        S_WRITE: begin
          if (!off_ok) st_r <= ST_RANGE;
          if (last_r) begin
            run_open_r <= 1'b0;
            pur_r <= P_COMMIT;
            rb_r  <= ~live_r;
          end
        end
        S_FORMAT: begin
          if (fmt_ok) begin
            vld_r[0] <= cnt_r + CW'(1);
          end else begin
            st_r <= ST_RANGE;
          end
          if (last_r) begin
            run_open_r <= 1'b0;
            cnt_r      <= '0;
            pur_r      <= P_META0;
            rb_r       <= 1'b0;
          end else if (fmt_ok) begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_SUM: begin
          if (issue) ci_r <= ci_r + CW'(1);
          p_v_r   <= issue;
          p_idx_r <= ci_r;
          if (p_v_r) begin
            s_r <= s_r + (p_idx_r[0] ? {16'b0, rg, 8'b0} : {24'b0, rg});
          end
        end
        S_FIN: begin
          ci_r <= '0;
          s_r  <= '0;
          case (pur_r)
            P_COMMIT: begin
              sig_r[fb] <= SIGNATURE_WORD;
              gen_r[fb] <= f_gen;
              ck_r[fb]  <= ~f_sum;
              live_r    <= fb;
              vld_r[live_r] <= '0;
              sig_r[live_r] <= 16'hffff;
              gen_r[live_r] <= 32'hffffffff;
              ck_r[live_r]  <= 16'hffff;
            end
            P_INIT0, P_INIT1: begin
              if (fin_valid) begin
                live_r     <= fb;
                vld_r[~fb] <= '0;
                sig_r[~fb] <= 16'hffff;
                gen_r[~fb] <= 32'hffffffff;
                ck_r[~fb]  <= 16'hffff;
              end else if (pur_r == P_INIT0) begin
                pur_r <= P_INIT1;
                rb_r  <= 1'b1;
              end else begin
                for (int b = 0; b < 2; b++) begin
                  vld_r[b] <= '0;
                  sig_r[b] <= 16'hffff;
                  gen_r[b] <= 32'hffffffff;
                  ck_r[b]  <= 16'hffff;
                end
                pur_r <= P_META0;
                rb_r  <= 1'b0;
                st_r  <= ST_FORMATTED;
              end
            end
            default: begin
              sig_r[0] <= SIGNATURE_WORD;
              gen_r[0] <= 32'd1;
              ck_r[0]  <= ~f_sum;
              live_r   <= 1'b0;
            end
          endcase
        end
        default: p_v_r <= 1'b0;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result beat longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted command did not raise busy");
  a_vld_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] <= CW'(DATA_BYTES) && vld_r[1] <= CW'(DATA_BYTES))
    else $error("bank fill count out of range");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status != 2'd3) else $error("bad status code");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !ram_we) else $error("bank write while idle");
`endif

endmodule
`default_nettype wire

// ----- sim/store_checker.sv -----
module store_checker #(
  parameter int DATA_BYTES = 960,
  parameter int META_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [9:0]  in_offset,
  input  wire logic [9:0]  in_length,
  input  wire logic [7:0]  in_data,
  input  wire logic        in_last,
  input  wire logic        out_strobe,
  input  wire logic [7:0]  out_read_data,
  input  wire logic        out_match,
  input  wire logic [1:0]  out_status,
  input  wire logic        out_active_bank,
  input  wire logic [31:0] out_generation,
  output int               fail_count,
  output int               pending_count,
  output int               beat_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbcs_pkg::*;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        match;
    logic [1:0]  status;
    logic        active_bank;
    logic [31:0] generation;
  } answer_t;

  logic [7:0]  bytes_q [2][DATA_BYTES];
  logic [15:0] sig_q [2];
  logic [31:0] gen_q [2];
  logic [15:0] ck_q [2];
  logic        live_q;
  logic        open_q;
  logic        cmp_ok_q;
  int          fmt_count_q;
  answer_t     answers_q [$];

  function automatic logic [15:0] page_sum(int b, logic [15:0] ck);
    logic [31:0] s;
    s = 0;
    for (int i = 0; i + 1 < DATA_BYTES; i += 2)
      s += {16'b0, bytes_q[b][i+1], bytes_q[b][i]};
    s += ck;
    s += sig_q[b];
    s += gen_q[b][15:0];
    s += gen_q[b][31:16];
    s += 32'hffff * ((META_BYTES - 8) / 2);
    s = {16'b0, s[15:0]} + {16'b0, s[31:16]};
    s = {16'b0, s[15:0]} + {16'b0, s[31:16]};
    return s[15:0];
  endfunction

  task automatic wipe_bank(int b);
    for (int i = 0; i < DATA_BYTES; i++) bytes_q[b][i] = ERASED_BYTE;
    sig_q[b] = 16'hffff;
    gen_q[b] = 32'hffffffff;
    ck_q[b] = 16'hffff;
  endtask

  task automatic seal_bank(int b, logic [31:0] g);
    sig_q[b] = SIGNATURE_WORD;
    gen_q[b] = g;
    ck_q[b] = ~page_sum(b, 16'h0);
  endtask

  function automatic bit bank_ok(int b);
    if (sig_q[b] != SIGNATURE_WORD) return 0;
    return (~page_sum(b, ck_q[b])) == 16'h0;
  endfunction

  task automatic commit_staged();
    int o;
    o = live_q ^ 1;
    seal_bank(o, gen_q[live_q] + 1);
    live_q = o;
    wipe_bank(o ^ 1);
  endtask

  task automatic stage_copy();
    for (int i = 0; i < DATA_BYTES; i++) bytes_q[live_q ^ 1][i] = bytes_q[live_q][i];
  endtask

  task automatic predict_store(logic [2:0] c, int off, int len, logic [7:0] d, bit lst);
    answer_t a;
    bit fmt_run, wr_run;
    a = '0;
    fmt_run = open_q && fmt_count_q > 0;
    wr_run = open_q && fmt_count_q == 0;
    if (c != CMD_COMPARE) cmp_ok_q = 1;
    if ((c == CMD_WRITE && !wr_run && open_q) || (c == CMD_FORMAT && !fmt_run && open_q) ||
        (c != CMD_WRITE && c != CMD_FORMAT)) begin
      if (open_q) begin
        if (fmt_count_q == 0) wipe_bank(live_q ^ 1);
        fmt_count_q = 0;
        open_q = 0;
      end
    end
    case (c)
      CMD_READ: begin
        if (off < DATA_BYTES) a.read_data = bytes_q[live_q][off];
        else a.status = ST_RANGE;
      end
      CMD_COMPARE: begin
        if (off < DATA_BYTES) begin
          if (bytes_q[live_q][off] != d) cmp_ok_q = 0;
        end else begin
          a.status = ST_RANGE;
          cmp_ok_q = 0;
        end
        if (lst) begin
          a.match = cmp_ok_q;
          cmp_ok_q = 1;
        end
      end
      CMD_WRITE: begin
        if (!open_q) begin
          stage_copy();
          open_q = 1;
          fmt_count_q = 0;
        end
        if (off < DATA_BYTES) bytes_q[live_q ^ 1][off] = d;
        else a.status = ST_RANGE;
        if (lst) begin
          commit_staged();
          open_q = 0;
        end
      end
      CMD_FILL: begin
        if (off + len > DATA_BYTES) a.status = ST_RANGE;
        else begin
          stage_copy();
          for (int i = off; i < off + len; i++) bytes_q[live_q ^ 1][i] = d;
          commit_staged();
        end
      end
      CMD_INIT: begin
        if (bank_ok(0)) begin
          live_q = 0;
          wipe_bank(1);
        end else if (bank_ok(1)) begin
          live_q = 1;
          wipe_bank(0);
        end else begin
          wipe_bank(0);
          wipe_bank(1);
          seal_bank(0, 1);
          live_q = 0;
          a.status = ST_FORMATTED;
        end
      end
      CMD_FORMAT: begin
        if (!open_q) begin
          wipe_bank(0);
          wipe_bank(1);
          open_q = 1;
          fmt_count_q = 0;
        end
        if (fmt_count_q < DATA_BYTES) begin
          bytes_q[0][fmt_count_q] = d;
          fmt_count_q++;
        end else a.status = ST_RANGE;
        if (lst) begin
          seal_bank(0, 1);
          live_q = 0;
          open_q = 0;
          fmt_count_q = 0;
        end
      end
      default: ;
    endcase
    a.active_bank = live_q;
    a.generation = gen_q[live_q];
    answers_q.push_back(a);
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (!rst_n) begin
      wipe_bank(0);
      wipe_bank(1);
      live_q = 0;
      open_q = 0;
      cmp_ok_q = 1;
      fmt_count_q = 0;
      answers_q.delete();
      fail_count = 0;
      beat_count = 0;
    end else begin
      if (out_strobe) begin
        beat_count++;
        if (answers_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("checker: result beat with nothing expected");
        end else begin
          e = answers_q.pop_front();
          if (e.read_data !== out_read_data || e.match !== out_match ||
              e.status !== out_status || e.active_bank !== out_active_bank ||
              e.generation !== out_generation) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("checker: mismatch exp rd=%h m=%b st=%0d bank=%b gen=%h,",
                       e.read_data, e.match, e.status, e.active_bank, e.generation);
              $display("checker:          got rd=%h m=%b st=%0d bank=%b gen=%h",
                       out_read_data, out_match, out_status, out_active_bank,
                       out_generation);
            end
          end
        end
      end
      if (start && !busy) begin
        beat_count++;
        predict_store(in_command, in_offset, in_length, in_data, in_last);
      end
    end
    pending_count = answers_q.size();
  end
endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dbcs_pkg::*;

  localparam int DATA_BYTES = 960;
  localparam int WATCH_LIMIT = 40000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_command = CMD_READ;
  logic [9:0] in_offset = 0;
  logic [9:0] in_length = 0;
  logic [7:0] in_data = 0;
  logic in_last = 0;
  logic out_strobe;
  logic [7:0] out_read_data;
  logic out_match;
  logic [1:0] out_status;
  logic out_active_bank;
  logic [31:0] out_generation;
  int fail_count, pending_count, beat_count;
  int idle_cycles;
  int last_beats;
  bit quiet;
  int sent;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  dual_bank_config_store DUT (.*);

  store_checker checker_i (.*);

  always @(posedge clk) begin
    if (beat_count != last_beats || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    last_beats <= beat_count;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic [2:0] c, int off, int len, logic [7:0] d, bit lst);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    in_command <= c;
    in_offset <= off[9:0];
    in_length <= len[9:0];
    in_data <= d;
    in_last <= lst;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic random_run();
    int k, base, n;
    k = $urandom_range(0, 99);
    n = $urandom_range(1, 5);
    base = $urandom_range(0, DATA_BYTES - 8);
    if (k < 20) send_beat(CMD_READ, $urandom_range(0, 1023), $urandom, 8'($urandom),
                          1'($urandom));
    else if (k < 38) begin
      for (int i = 0; i < n; i++)
        send_beat(CMD_COMPARE, (k < 36) ? base + i : $urandom_range(0, 1023), $urandom,
                  8'($urandom), i == n - 1);
    end else if (k < 62) begin
      for (int i = 0; i < n; i++)
        send_beat(CMD_WRITE, (k < 60) ? base + i : $urandom_range(0, 1023), $urandom,
                  8'($urandom), (k < 58) ? (i == n - 1) : 0);
    end else if (k < 80) begin
      send_beat(CMD_FILL, (k < 77) ? base : $urandom_range(0, 1023),
                (k < 77) ? $urandom_range(0, 40) : $urandom_range(0, 1023), 8'($urandom),
                1'($urandom));
    end else if (k < 88) send_beat(CMD_INIT, $urandom, $urandom, 8'($urandom), 1'($urandom));
    else if (k < 94) begin
      for (int i = 0; i < n; i++) send_beat(CMD_FORMAT, $urandom, $urandom, 8'($urandom),
                                            (k < 93) ? (i == n - 1) : 0);
    end else send_beat(3'($urandom_range(6, 7)), $urandom, $urandom, 8'($urandom),
                       1'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_beat(CMD_READ, 0, 0, 0, 0);
    send_beat(CMD_READ, 1023, 0, 0, 0);
    send_beat(CMD_INIT, 0, 0, 0, 0);
    send_beat(CMD_WRITE, 0, 0, 8'h00, 0);
    send_beat(CMD_WRITE, 1000, 0, 8'h12, 0);
    send_beat(CMD_WRITE, 959, 0, 8'hff, 1);
    send_beat(CMD_COMPARE, 0, 0, 8'h00, 0);
    send_beat(CMD_COMPARE, 959, 0, 8'hff, 1);
    send_beat(CMD_COMPARE, 1023, 0, 8'h00, 1);
    send_beat(CMD_COMPARE, 0, 0, 8'h55, 0);
    send_beat(CMD_READ, 959, 0, 0, 0);
    send_beat(CMD_COMPARE, 0, 0, 8'h00, 1);
    send_beat(CMD_FILL, 0, 960, 8'ha5, 0);
    send_beat(CMD_FILL, 1, 960, 8'h5a, 1);
    send_beat(CMD_FILL, 1023, 1023, 8'h5a, 1);
    send_beat(CMD_FILL, 10, 0, 8'h00, 0);
    send_beat(CMD_WRITE, 3, 0, 8'h33, 0);
    send_beat(CMD_READ, 3, 0, 0, 0);
    send_beat(CMD_INIT, 0, 0, 0, 0);
    send_beat(CMD_FORMAT, 0, 0, 8'h11, 0);
    send_beat(CMD_READ, 0, 0, 0, 0);
    send_beat(CMD_INIT, 0, 0, 0, 0);
    send_beat(CMD_FORMAT, 0, 0, 8'h22, 1);
    send_beat(3'd6, 0, 0, 0, 0);
    send_beat(3'd7, 1023, 1023, 8'hff, 1);
    while (sent < 800) begin
      if (sent > 700) quiet = 1;
      random_run();
    end
    start <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d beats: reads, compare runs, write runs, fills, init and format.",
             sent);
    $display("Range errors, interrupted runs and unused codes were mixed in.");
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
